>>> rtl/dftd_pkg.sv
// shared constants, control structs and twiddle/saturation functions for the dft block
package dftd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int BIN_W = 6;
  localparam int OUT_W = 22;
  localparam int SAT_W = 48;

  localparam int DFTD_POINTS = 64;
  localparam int DFTD_TWIDDLE_BITS = 16;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  localparam longint OUT_MAX = 64'sd2097151;
  localparam longint OUT_MIN = -64'sd2097152;
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(OUT_MAX);
  localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(OUT_MIN);

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             last_bin;
    logic             mode;
    logic [BIN_W-1:0] bin;
  } beat_t;

  typedef struct packed {
    logic             valid;
    logic             mode;
    logic             last_bin;
    logic [BIN_W-1:0] bin;
  } res_ctl_t;

  function automatic longint to_tw(longint v, int tbits);
    longint lim;
    longint r;
    longint vv;
    int     sh;
    sh = 31 - tbits;
    lim = (longint'(1) << (tbits - 1)) - 1;
    vv = (v < 0) ? 64'sd0 : v;
    r = (vv + (longint'(1) << (sh - 1))) >>> sh;
    return (r > lim) ? lim : r;
  endfunction

  // shift-subtract quotient, used only for rom constants
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // quarter-wave taylor series, then quadrant fold
  function automatic longint tw_entry(longint unsigned phi, longint unsigned quad, int tbits,
                                      bit want_sin);
    longint unsigned phi2;
    longint unsigned ts;
    longint unsigned tc;
    longint unsigned dv_s;
    longint unsigned dv_c;
    longint          ss;
    longint          cs;
    longint          c;
    longint          s;
    longint          res;
    phi2 = (phi * phi) >> 30;
    ts = phi;
    tc = ONE_Q30;
    ss = longint'(phi);
    cs = longint'(ONE_Q30);
    for (int i = 1; i <= 15; i++) begin
      dv_s = longint'(2 * i) * longint'(2 * i + 1);
      dv_c = longint'(2 * i - 1) * longint'(2 * i);
      ts = udiv((ts * phi2) >> 30, dv_s);
      tc = udiv((tc * phi2) >> 30, dv_c);
      if ((i & 1) != 0) begin
        ss = ss - longint'(ts);
        cs = cs - longint'(tc);
      end else begin
        ss = ss + longint'(ts);
        cs = cs + longint'(tc);
      end
    end
    c = to_tw(cs, tbits);
    s = to_tw(ss, tbits);
    unique case (quad[1:0])
      2'd0: res = want_sin ? s : c;
      2'd1: res = want_sin ? c : -s;
      2'd2: res = want_sin ? -s : -c;
      2'd3: res = want_sin ? -c : s;
      default: res = 64'sd0;
    endcase
    return res;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(logic signed [SAT_W-1:0] v);
    if (v > SAT_HI) begin
      return SAT_HI[OUT_W-1:0];
    end else if (v < SAT_LO) begin
      return SAT_LO[OUT_W-1:0];
    end
    return v[OUT_W-1:0];
  endfunction

endpackage

>>> rtl/dftd_if.sv
// valid/ready channel interfaces for samples, results and configuration
interface dftd_in_if;
  import dftd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface dftd_out_if;
  import dftd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [BIN_W-1:0]        bin_index;
  logic signed [OUT_W-1:0] real_part;
  logic signed [OUT_W-1:0] imag_part;
  logic                    last_bin;
  modport source (output valid, output bin_index, output real_part, output imag_part,
                  output last_bin, input ready);
  modport sink (input valid, input bin_index, input real_part, input imag_part,
                input last_bin, output ready);
endinterface

interface dftd_cfg_if;
  logic valid;
  logic ready;
  logic inverse_mode;
  modport source (output valid, output inverse_mode, input ready);
  modport sink (input valid, input inverse_mode, output ready);
endinterface

>>> rtl/dft_direct.sv
// direct n-point dft top level: sample chain, sequencer, mac and output scaling
// each bin's beats pass ctl1, ctl2 and the accumulator in the mac, then ctl_a, ctl_b and the
//   result register in the scale stage; bin k+1 starts only after bin k is taken
// a run loads POINTS samples (one sample per cycle), then the single multiply-accumulate unit,
//   fed one sample per cycle from the circulating chain, computes POINTS bins; between bins it
//   waits for the mac and scale to drain, and the next run loads after its last beat is issued
// reset: synchronous, clears the sequencer, counters, mode and all valid flags
module dft_direct #(
  parameter int POINTS = dftd_pkg::DFTD_POINTS,
  parameter int TWIDDLE_BITS = dftd_pkg::DFTD_TWIDDLE_BITS
) (
  input logic        clk,
  input logic        rst,
  dftd_cfg_if.sink   cfg,
  dftd_in_if.sink    samples,
  dftd_out_if.source results
);
  import dftd_pkg::*;

  localparam int LogN = $clog2(POINTS);
  localparam int AccW = SAMPLE_W + TWIDDLE_BITS + LogN;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_CALC = 2'b10
  } state_t;

  state_t                     state;
  state_t                     state_next;
  logic [LogN-1:0]            load_cnt;
  logic [LogN-1:0]            n_cnt;
  logic [LogN-1:0]            k_cnt;
  logic [LogN-1:0]            m_idx;
  logic [LogN:0]              m_sum;
  logic [LogN:0]              m_wrap;
  logic                       mode;
  logic                       in_take;
  logic                       issue;
  logic                       shift_en;
  logic                       last_load;
  logic                       last_n;
  logic                       last_k;
  logic                       mac_busy;
  logic                       scale_busy;
  logic signed [SAMPLE_W-1:0] cell_q [POINTS];
  logic signed [SAMPLE_W-1:0] tail_d;
  beat_t                      beat;
  res_ctl_t                   done;
  logic signed [AccW-1:0]     acc_re;
  logic signed [AccW-1:0]     acc_im;

  assign samples.ready = (state == ST_LOAD);
  assign cfg.ready = 1'b1;

  always_comb begin
    in_take = samples.valid && samples.ready;
    last_load = (load_cnt == LogN'(POINTS - 1));
    last_n = (n_cnt == LogN'(POINTS - 1));
    last_k = (k_cnt == LogN'(POINTS - 1));
    issue = (state == ST_CALC) && ((n_cnt != '0) || !(mac_busy || scale_busy));
    shift_en = in_take || issue;
    tail_d = (state == ST_LOAD) ? samples.sample : cell_q[0];
    m_sum = {1'b0, m_idx} + {1'b0, k_cnt};
    m_wrap = (m_sum >= (LogN+1)'(POINTS)) ? m_sum - (LogN+1)'(POINTS) : m_sum;
    beat.valid = issue;
    beat.first = (n_cnt == '0);
    beat.last = last_n;
    beat.last_bin = last_k;
    beat.mode = mode;
    beat.bin = BIN_W'(k_cnt);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_take && last_load) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        if (issue && last_n && last_k) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      load_cnt <= '0;
      n_cnt <= '0;
      k_cnt <= '0;
      m_idx <= '0;
      mode <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        mode <= cfg.inverse_mode;
      end
      if (in_take) begin
        load_cnt <= last_load ? '0 : load_cnt + LogN'(1);
      end
      if (issue) begin
        if (last_n) begin
          n_cnt <= '0;
          m_idx <= '0;
          k_cnt <= last_k ? '0 : k_cnt + LogN'(1);
        end else begin
          n_cnt <= n_cnt + LogN'(1);
          m_idx <= m_wrap[LogN-1:0];
        end
      end
    end
  end

  // circulating chain: head at cell 0, new samples and rotation enter at the tail
  for (genvar i = 0; i < POINTS; i++) begin : g_cell
    if (i == POINTS - 1) begin : g_tail
      dftd_cell u_cell (
        .clk   (clk),
        .shift (shift_en),
        .d     (tail_d),
        .q     (cell_q[i])
      );
    end else begin : g_body
      dftd_cell u_cell (
        .clk   (clk),
        .shift (shift_en),
        .d     (cell_q[i+1]),
        .q     (cell_q[i])
      );
    end
  end

  dftd_mac #(
    .POINTS       (POINTS),
    .TWIDDLE_BITS (TWIDDLE_BITS)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .beat   (beat),
    .x      (cell_q[0]),
    .m_idx  (m_idx),
    .done   (done),
    .acc_re (acc_re),
    .acc_im (acc_im),
    .busy   (mac_busy)
  );

  dftd_scale #(
    .POINTS       (POINTS),
    .TWIDDLE_BITS (TWIDDLE_BITS)
  ) u_scale (
    .clk     (clk),
    .rst     (rst),
    .done    (done),
    .acc_re  (acc_re),
    .acc_im  (acc_im),
    .results (results),
    .busy    (scale_busy)
  );

endmodule

>>> rtl/dftd_cell.sv
// one sample cell of the circulating sample chain
module dftd_cell (
  input  logic                                clk,
  input  logic                                shift,
  input  logic signed [dftd_pkg::SAMPLE_W-1:0] d,
  output logic signed [dftd_pkg::SAMPLE_W-1:0] q
);
  import dftd_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

>>> rtl/dftd_mac.sv
// twiddle rom and complex multiply-accumulate pipeline
module dftd_mac #(
  parameter int POINTS = dftd_pkg::DFTD_POINTS,
  parameter int TWIDDLE_BITS = dftd_pkg::DFTD_TWIDDLE_BITS
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  dftd_pkg::beat_t                          beat,
  input  logic signed [dftd_pkg::SAMPLE_W-1:0]     x,
  input  logic [$clog2(POINTS)-1:0]                m_idx,
  output dftd_pkg::res_ctl_t                       done,
  output logic signed
    [dftd_pkg::SAMPLE_W+TWIDDLE_BITS+$clog2(POINTS)-1:0] acc_re,
  output logic signed
    [dftd_pkg::SAMPLE_W+TWIDDLE_BITS+$clog2(POINTS)-1:0] acc_im,
  output logic                                     busy
);
  import dftd_pkg::*;

  localparam int LogN = $clog2(POINTS);
  localparam int ProdW = SAMPLE_W + TWIDDLE_BITS;
  localparam int AccW = ProdW + LogN;

  logic signed [TWIDDLE_BITS-1:0] cos_rom [POINTS];
  logic signed [TWIDDLE_BITS-1:0] sin_rom [POINTS];

  for (genvar m = 0; m < POINTS; m++) begin : g_rom
    localparam longint unsigned Quad = (4 * m) / POINTS;
    localparam longint unsigned Rem = 4 * m - Quad * POINTS;
    localparam longint unsigned Phi = (PI_HALF_Q30 * Rem) / POINTS;
    localparam longint CosVal = tw_entry(Phi, Quad, TWIDDLE_BITS, 1'b0);
    localparam longint SinVal = tw_entry(Phi, Quad, TWIDDLE_BITS, 1'b1);
    assign cos_rom[m] = CosVal[TWIDDLE_BITS-1:0];
    assign sin_rom[m] = SinVal[TWIDDLE_BITS-1:0];
  end

  beat_t                          ctl1;
  beat_t                          ctl2;
  logic signed [SAMPLE_W-1:0]     x1;
  logic signed [TWIDDLE_BITS-1:0] cos1;
  logic signed [TWIDDLE_BITS-1:0] sin1;
  logic signed [ProdW-1:0]        p_re;
  logic signed [ProdW-1:0]        p_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      done <= '0;
    end else begin
      ctl1 <= beat;
      ctl2 <= ctl1;
      done.valid <= ctl2.valid && ctl2.last;
      done.mode <= ctl2.mode;
      done.last_bin <= ctl2.last_bin;
      done.bin <= ctl2.bin;
    end
  end

  always_ff @(posedge clk) begin
    x1 <= x;
    cos1 <= cos_rom[m_idx];
    sin1 <= sin_rom[m_idx];
    p_re <= x1 * cos1;
    p_im <= x1 * sin1;
    if (ctl2.valid) begin
      if (ctl2.first) begin
        acc_re <= AccW'(p_re);
        acc_im <= -AccW'(p_im);
      end else begin
        acc_re <= acc_re + AccW'(p_re);
        acc_im <= acc_im - AccW'(p_im);
      end
    end
  end

  assign busy = ctl1.valid | ctl2.valid | done.valid;

endmodule

>>> rtl/dftd_scale.sv
// output rounding, divide by points for inverse, saturation and result register
module dftd_scale #(
  parameter int POINTS = dftd_pkg::DFTD_POINTS,
  parameter int TWIDDLE_BITS = dftd_pkg::DFTD_TWIDDLE_BITS
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  dftd_pkg::res_ctl_t                       done,
  input  logic signed
    [dftd_pkg::SAMPLE_W+TWIDDLE_BITS+$clog2(POINTS)-1:0] acc_re,
  input  logic signed
    [dftd_pkg::SAMPLE_W+TWIDDLE_BITS+$clog2(POINTS)-1:0] acc_im,
  dftd_out_if.source                               results,
  output logic                                     busy
);
  import dftd_pkg::*;

  localparam int LogN = $clog2(POINTS);
  localparam int AccW = SAMPLE_W + TWIDDLE_BITS + LogN;
  localparam int SumW = AccW + 1;
  localparam int ZW = SumW - (TWIDDLE_BITS - 1);
  localparam int ZB = LogN + 16;
  localparam int UW = LogN + ZB + 1;
  localparam int ShiftS = UW + LogN;
  localparam int MW = UW + 2;
  localparam int QW = ZB + 1;

  localparam logic signed [SumW-1:0] RndFwd = SumW'(longint'(1) << (TWIDDLE_BITS - 2));
  localparam logic signed [SumW-1:0] RndInv =
    SumW'(longint'(POINTS) << (TWIDDLE_BITS - 2));
  localparam logic [UW-1:0] Bias = UW'(longint'(POINTS) << ZB);
  localparam logic [MW-1:0] Magic =
    MW'(((longint'(1) << ShiftS) + longint'(POINTS) - 1) / longint'(POINTS));

  logic signed [SumW-1:0] sum_re;
  logic signed [SumW-1:0] sum_im;
  logic signed [ZW-1:0]   za_re_c;
  logic signed [ZW-1:0]   za_im_c;
  logic [UW-1:0]          u_c;

  res_ctl_t               ctl_a;
  res_ctl_t               ctl_b;
  logic signed [ZW-1:0]   za_re_a;
  logic signed [ZW-1:0]   za_im_a;
  logic [UW-1:0]          u_a;
  logic signed [ZW-1:0]   za_re_b;
  logic signed [ZW-1:0]   za_im_b;
  logic [UW+MW-1:0]       prod_b;

  logic [QW-1:0]          q_c;
  logic signed [QW-1:0]   qs_c;

  always_comb begin
    sum_re = SumW'(acc_re) + (done.mode ? RndInv : RndFwd);
    sum_im = SumW'(acc_im) + RndFwd;
    za_re_c = sum_re[SumW-1:TWIDDLE_BITS-1];
    za_im_c = sum_im[SumW-1:TWIDDLE_BITS-1];
    u_c = UW'(za_re_c) + Bias;
    q_c = prod_b[ShiftS +: QW];
    qs_c = {~q_c[QW-1], q_c[QW-2:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
      ctl_b <= '0;
      results.valid <= 1'b0;
    end else begin
      ctl_a <= done;
      ctl_b <= ctl_a;
      if (ctl_b.valid) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    za_re_a <= za_re_c;
    za_im_a <= za_im_c;
    u_a <= u_c;
    za_re_b <= za_re_a;
    za_im_b <= za_im_a;
    prod_b <= u_a * Magic;
    if (ctl_b.valid) begin
      results.bin_index <= ctl_b.bin;
      results.last_bin <= ctl_b.last_bin;
      results.real_part <= ctl_b.mode ? sat_out(SAT_W'(qs_c)) : sat_out(SAT_W'(za_re_b));
      results.imag_part <= ctl_b.mode ? '0 : sat_out(SAT_W'(za_im_b));
    end
  end

  assign busy = ctl_a.valid | ctl_b.valid | results.valid;

endmodule

>>> rtl/dftd_checker.sv
// port-level assertions for the dft block and their bind to the top level
module dftd_props #(
  parameter int POINTS = dftd_pkg::DFTD_POINTS
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [dftd_pkg::BIN_W-1:0]          out_bin,
  input logic                                out_last,
  input logic signed [dftd_pkg::OUT_W-1:0]   out_real
);
  import dftd_pkg::*;

  logic [BIN_W-1:0] exp_bin;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_bin <= '0;
    end else if (out_valid && out_ready) begin
      exp_bin <= out_last ? '0 : out_bin + BIN_W'(1);
    end
  end

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_bin == BIN_W'(POINTS - 1))
    else $error("last flag on a bin other than the final one");

  a_bin_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_bin == exp_bin)
    else $error("bins out of order");

  a_run_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("result right after the final transaction of a run");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_bin) && $stable(out_real))
    else $error("stalled result changed");

endmodule

bind dft_direct dftd_props #(
  .POINTS (POINTS)
) u_dftd_props (
  .clk       (clk),
  .rst       (rst),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_bin   (results.bin_index),
  .out_last  (results.last_bin),
  .out_real  (results.real_part)
);
